[rtl/color_ramp_key_interpolator_assert.svh]
// Assertion macros used by the checker file
`ifndef COLOR_RAMP_KEY_INTERPOLATOR_ASSERT_SVH
`define COLOR_RAMP_KEY_INTERPOLATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define CRKI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define CRKI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/crki_pkg.sv]
`timescale 1ns / 1ps
package crki_pkg;

  localparam int MaxKeysDef  = 16;
  localparam int TimeBitsDef = 16;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] CfgRangeStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeEnd   = 1'd1;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindRemove = 2'd1,
    KindAlter  = 2'd2,
    KindEval   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatBad   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_time;
    logic [31:0] key_color;
    logic [3:0]  key_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] color_out;
    logic [1:0]  status;
  } out_item_t;

  // Divider request and reply between the controller and the divider
  typedef struct packed {
    logic        go;
    logic [41:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [41:0] quo;
    logic [32:0] rem;
  } div_rsp_t;

endpackage

[rtl/crki_div.sv]
`timescale 1ns / 1ps
module crki_div
  import crki_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NumW = 42;
  localparam int DenW = 33;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DenW:0]   trial;

  // One quotient bit per cycle while busy, restoring
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DenW-1:0], quo_r[NumW-1]};
    if (req.go) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[DenW-1:0];

endmodule

[rtl/crki_ctrl.sv]
`timescale 1ns / 1ps
module crki_ctrl
  import crki_pkg::*;
#(
  parameter int MAX_KEYS  = MaxKeysDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_item_t      in_item,
  input  logic [15:0]   range_start,
  input  logic [15:0]   range_end,
  output logic          out_valid,
  output out_item_t     out_item,
  output div_req_t      dreq,
  input  div_rsp_t      drsp
);

  localparam int IdxW = $clog2(MAX_KEYS);
  localparam int CntW = $clog2(MAX_KEYS + 1);
  localparam int EntW = TIME_BITS + 32;

  typedef enum logic [3:0] {
    StIdle, StRmRd, StRmWr, StInsRd, StInsWr, StEvRd, StEvChk,
    StEvRd2, StDiv, StDivWait, StDone
  } state_t;

  // Key store: time and color in one word
  logic [EntW-1:0] mem [MAX_KEYS];
  logic [EntW-1:0] rdata_r;
  logic [IdxW-1:0] raddr;
  logic            wen;
  logic [IdxW-1:0] waddr;
  logic [EntW-1:0] wdata;

  state_t          st_r;
  logic            busy_r, oval_r;
  out_item_t       oitem_r;
  logic [1:0]      kind_r;
  logic [TIME_BITS-1:0] t_r;
  logic [31:0]     c_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] pos_r;
  logic [CntW-1:0] end_r;
  logic [EntW-1:0] prev_r;
  logic [TIME_BITS-1:0] den_r, dt_r;
  logic [31:0]     ca_r, cb_r;
  logic [1:0]      ch_r;
  logic [31:0]     acc_r;
  logic            go_r;
  logic [41:0]     num_r;
  logic [15:0]     ktime;
  logic [TIME_BITS-1:0] ktime_w, rs_w, re_w, tclamp;
  logic [TIME_BITS-1:0] rd_t;
  logic [31:0]     rd_c;
  logic [TIME_BITS-1:0] pv_t;
  logic [7:0]      va, vb;
  logic [41:0]     num_c;
  logic [32:0]     r2;
  logic [41:0]     qr;
  logic [7:0]      qsat;

  assign ktime   = in_item.key_time;
  assign ktime_w = TIME_BITS'(ktime);
  assign rs_w    = TIME_BITS'(range_start);
  assign re_w    = TIME_BITS'(range_end);
  assign rd_t    = rdata_r[EntW-1:32];
  assign rd_c    = rdata_r[31:0];
  assign pv_t    = prev_r[EntW-1:32];

  // Clamp alter time to the configured range
  always_comb begin
    if (ktime_w < rs_w)      tclamp = rs_w;
    else if (ktime_w > re_w) tclamp = re_w;
    else                     tclamp = ktime_w;
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Read address and write-back by state
  always_comb begin
    raddr = pos_r[IdxW-1:0];
    wen   = 1'b0;
    waddr = pos_r[IdxW-1:0];
    wdata = {t_r, c_r};
    unique case (st_r)
      StRmRd:  raddr = IdxW'(pos_r + 1'b1);
      StRmWr: begin
        wen   = 1'b1;
        wdata = rdata_r;
        raddr = IdxW'(pos_r + 2'd2);
      end
      StInsRd: raddr = IdxW'(pos_r - 1'b1);
      StInsWr: begin
        wen = 1'b1;
        if (pos_r != '0 && rd_t > t_r) begin
          wdata = rdata_r;
          raddr = IdxW'(pos_r - 2'd2);
        end
      end
      StEvRd2: raddr = IdxW'(pos_r + 1'b1);
      default: ;
    endcase
  end

  // Channel terms for the current divide
  always_comb begin
    va    = ca_r[8*ch_r +: 8];
    vb    = cb_r[8*ch_r +: 8];
    num_c = 42'(va) * 42'(den_r - dt_r) + 42'(vb) * 42'(dt_r);
    qr    = drsp.quo;
    r2    = {drsp.rem[31:0], 1'b0};
    if (r2 > 33'(den_r) || (r2 == 33'(den_r) && qr[0]))
      qr = qr + 1'b1;
    qsat  = (qr > 42'd255) ? 8'hFF : qr[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= StIdle;
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      cnt_r  <= '0;
      go_r   <= 1'b0;
    end else begin
      oval_r <= 1'b0;
      go_r   <= 1'b0;
      unique case (st_r)
        StIdle: if (start) begin
          busy_r <= 1'b1;
          kind_r <= in_item.kind;
          c_r    <= in_item.key_color;
          t_r    <= (in_item.kind == KindAlter) ? tclamp : ktime_w;
          oitem_r.color_out <= '0;
          unique case (in_item.kind)
            KindInsert: begin
              if (cnt_r >= CntW'(MAX_KEYS)) begin
                oitem_r.status <= StatFull;
                st_r <= StDone;
              end else begin
                oitem_r.status <= StatOk;
                pos_r <= cnt_r;
                st_r  <= StInsRd;
              end
            end
            KindRemove, KindAlter: begin
              if (CntW'(in_item.key_index) >= cnt_r) begin
                oitem_r.status <= StatBad;
                st_r <= StDone;
              end else begin
                oitem_r.status <= StatOk;
                pos_r <= CntW'(in_item.key_index);
                end_r <= cnt_r - 1'b1;
                st_r  <= StRmRd;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                oitem_r.status <= StatBad;
                st_r <= StDone;
              end else begin
                oitem_r.status <= StatOk;
                end_r <= cnt_r - 1'b1;
                if (ktime_w <= rs_w) pos_r <= '0;
                else if (ktime_w >= re_w) pos_r <= cnt_r - 1'b1;
                else pos_r <= '0;
                st_r <= StEvRd;
              end
            end
          endcase
        end
        // Shift entries down over the removed slot
        StRmRd: begin
          if (pos_r + 1'b1 >= end_r + 1'b1) begin
            cnt_r <= cnt_r - 1'b1;
            if (kind_r == KindAlter) begin
              pos_r <= cnt_r - 1'b1;
              st_r  <= StInsRd;
            end else st_r <= StDone;
          end else st_r <= StRmWr;
        end
        StRmWr: begin
          if (pos_r + 2'd2 >= end_r + 1'b1) begin
            cnt_r <= cnt_r - 1'b1;
            if (kind_r == KindAlter) begin
              pos_r <= cnt_r - 1'b1;
              st_r  <= StInsRd;
            end else begin
              pos_r <= pos_r + 1'b1;
              st_r  <= StDone;
            end
          end else pos_r <= pos_r + 1'b1;
        end
        // Shift larger entries up, then drop the key in
        StInsRd: st_r <= StInsWr;
        StInsWr: begin
          if (pos_r != '0 && rd_t > t_r) begin
            pos_r <= pos_r - 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            st_r  <= StDone;
          end
        end
        // Scan for the enclosing pair
        StEvRd: st_r <= StEvChk;
        StEvChk: begin
          if (t_r <= rs_w || t_r >= re_w || rd_t == t_r || pos_r == end_r) begin
            oitem_r.color_out <= rd_c;
            st_r <= StDone;
          end else begin
            prev_r <= rdata_r;
            st_r   <= StEvRd2;
          end
        end
        StEvRd2: begin
          if (rd_t == t_r) begin
            oitem_r.color_out <= rd_c;
            st_r <= StDone;
          end else if (pv_t <= t_r && rd_t > t_r) begin
            ca_r  <= prev_r[31:0];
            cb_r  <= rd_c;
            den_r <= rd_t - pv_t;
            dt_r  <= t_r - pv_t;
            ch_r  <= 2'd0;
            st_r  <= StDiv;
          end else if (pos_r == end_r) begin
            oitem_r.color_out <= rd_c;
            st_r <= StDone;
          end else begin
            prev_r <= rdata_r;
            pos_r  <= pos_r + 1'b1;
          end
        end
        StDiv: begin
          num_r <= num_c;
          go_r  <= 1'b1;
          st_r  <= StDivWait;
        end
        StDivWait: if (drsp.done) begin
          acc_r <= {qsat, acc_r[31:8]};
          ch_r  <= ch_r + 1'b1;
          if (ch_r == 2'd3) begin
            oitem_r.color_out <= {qsat, acc_r[31:8]};
            st_r <= StDone;
          end else st_r <= StDiv;
        end
        StDone: begin
          oval_r <= 1'b1;
          busy_r <= 1'b0;
          st_r   <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  // The first StEvRd2 cycle sees entry zero twice and only advances; after
  // that rdata holds entry pos and prev holds entry pos-1.
  assign busy      = busy_r;
  assign out_valid = oval_r;
  assign out_item  = oitem_r;
  assign dreq.go   = go_r;
  assign dreq.num  = num_r;
  assign dreq.den  = 33'(den_r);

endmodule

[rtl/color_ramp_key_interpolator.sv]
`timescale 1ns / 1ps
// Color ramp key interpolator.
// Input: pulse start with in_item while busy is low; the beat is taken then.
// Kinds: insert key, remove key at index, alter key at index, evaluate.
// Output: out_valid strobes for one cycle with out_item; exactly one result
// per item. The receiver cannot stall, so nothing is held back.
// Config: cfg_we with cfg_idx (0 range start, 1 range end) and cfg_data,
// written at once; write only while busy is low.
// Storage: keys live in one single-port-read memory; insert and remove
// move one entry per cycle, and alter does both.
// Evaluate scans one key per cycle, then runs a 42-bit serial divide per
// channel. Status-only results go straight from StIdle to StDone.
// Reset: key count cleared, range 0..25600; memory contents stay unknown
// but are never used before being written.
module color_ramp_key_interpolator
  import crki_pkg::*;
#(
  parameter int MAX_KEYS  = MaxKeysDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_item,
  output logic                out_valid,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [15:0] range_start_r, range_end_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // Range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= 16'd0;
      range_end_r   <= 16'd25600;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgRangeStart: range_start_r <= cfg_data;
        CfgRangeEnd:   range_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  crki_ctrl #(.MAX_KEYS(MAX_KEYS), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_item,
    .range_start(range_start_r), .range_end(range_end_r),
    .out_valid, .out_item, .dreq, .drsp
  );

  crki_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

endmodule

[rtl/crki_checker.sv]
`timescale 1ns / 1ps
`include "color_ramp_key_interpolator_assert.svh"
module crki_checker
  import crki_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  `CRKI_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `CRKI_ASSERT_IMP(a_res_busy, clk, rst_n, out_valid, !busy, "result while busy")
  `CRKI_ASSERT_IMP(a_stat_ok, clk, rst_n, out_valid, out_item.status != 2'd3, "bad status")
  `CRKI_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_item.status != StatOk,
    out_item.color_out == '0, "color on error")

endmodule

bind color_ramp_key_interpolator crki_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import crki_pkg::*;

  localparam int NumKeys = 16;

  // Expected-result store and checker for the key table
  class ramp_scoreboard;
    out_item_t pending[$];
    int unsigned mismatches;
    int unsigned strays;
    logic [15:0] key_times[NumKeys];
    logic [31:0] key_colors[NumKeys];
    int unsigned key_count;
    logic [15:0] lo_time;
    logic [15:0] hi_time;

    function new();
      key_count = 0;
      lo_time = 16'd0;
      hi_time = 16'd25600;
      mismatches = 0;
      strays = 0;
    endfunction

    function void set_range(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == CfgRangeStart) lo_time = val;
      else hi_time = val;
    endfunction

    // Sorted placement after equal times
    function void place(logic [15:0] t, logic [31:0] c);
      int unsigned pos;
      pos = key_count;
      while (pos > 0 && key_times[pos-1] > t) begin
        key_times[pos] = key_times[pos-1];
        key_colors[pos] = key_colors[pos-1];
        pos--;
      end
      key_times[pos] = t;
      key_colors[pos] = c;
      key_count++;
    endfunction

    function void drop(int unsigned idx);
      for (int unsigned i = idx; i + 1 < key_count; i++) begin
        key_times[i] = key_times[i+1];
        key_colors[i] = key_colors[i+1];
      end
      key_count--;
    endfunction

    // Per-channel linear blend, round half to even
    function logic [31:0] blend(int unsigned t, int unsigned ta, logic [31:0] ca,
                                int unsigned tb, logic [31:0] cb);
      longint unsigned den, dt, va, vb, num, q, r2;
      logic [31:0] res;
      den = tb - ta;
      dt = t - ta;
      res = '0;
      for (int sh = 0; sh < 32; sh += 8) begin
        va = (ca >> sh) & 8'hFF;
        vb = (cb >> sh) & 8'hFF;
        num = va * (den - dt) + vb * dt;
        q = num / den;
        r2 = (num % den) * 2;
        if (r2 > den || (r2 == den && q[0])) q++;
        if (q > 255) q = 255;
        res |= 32'(q) << sh;
      end
      return res;
    endfunction

    function logic [31:0] curve_at(logic [15:0] t);
      int unsigned last;
      last = key_count - 1;
      if (t <= lo_time) return key_colors[0];
      if (t >= hi_time) return key_colors[last];
      for (int unsigned i = 0; i < last; i++) begin
        if (key_times[i] == t) return key_colors[i];
        if (key_times[i] <= t && key_times[i+1] > t)
          return blend(t, key_times[i], key_colors[i], key_times[i+1], key_colors[i+1]);
      end
      return key_colors[last];
    endfunction

    // Note an accepted input beat and queue its result
    function void note_item(in_item_t it);
      out_item_t r;
      logic [15:0] t;
      r.color_out = '0;
      r.status = StatOk;
      t = it.key_time;
      case (kind_t'(it.kind))
        KindInsert: begin
          if (key_count >= NumKeys) r.status = StatFull;
          else place(t, it.key_color);
        end
        KindRemove: begin
          if (it.key_index >= key_count) r.status = StatBad;
          else drop(it.key_index);
        end
        KindAlter: begin
          if (it.key_index >= key_count) r.status = StatBad;
          else begin
            if (t < lo_time) t = lo_time;
            else if (t > hi_time) t = hi_time;
            drop(it.key_index);
            place(t, it.key_color);
          end
        end
        default: begin
          if (key_count == 0) r.status = StatBad;
          else r.color_out = curve_at(t);
        end
      endcase
      pending.push_back(r);
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        strays++;
        if (mismatches <= 10) $display("unexpected result beat: %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.color_out !== exp_r.color_out || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: color exp %h got %h, status exp %0d got %0d",
                   exp_r.color_out, got.color_out, exp_r.status, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ramp_scoreboard ramp_sb = new();
  int idle_pct = 0;

  always #4 clk = ~clk;

  color_ramp_key_interpolator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Check every result beat at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) ramp_sb.check_result(out_item);
  end

  // Send one beat, with optional random idle cycles first; start stays high
  // after the beat is taken, which is harmless while busy is up
  task automatic send_beat(kind_t k, logic [15:0] t, logic [31:0] c, logic [3:0] idx);
    in_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    it.kind = k;
    it.key_time = t;
    it.key_color = c;
    it.key_index = idx;
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ramp_sb.note_item(it);
    @(negedge clk);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (ramp_sb.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_range(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    ramp_sb.set_range(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly keys near the range, sometimes anywhere
  function automatic logic [15:0] pick_time();
    int unsigned lo, hi;
    lo = ramp_sb.lo_time;
    hi = ramp_sb.hi_time;
    if (lo > hi) begin
      lo = ramp_sb.hi_time;
      hi = ramp_sb.lo_time;
    end
    if ($urandom_range(3) == 0) return 16'($urandom);
    if ($urandom_range(5) == 0 && ramp_sb.key_count > 0)
      return ramp_sb.key_times[$urandom_range(ramp_sb.key_count - 1)];
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic random_phase(int n);
    kind_t k;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (ramp_sb.key_count < 4) k = (pick < 60) ? KindInsert : KindEval;
      else if (ramp_sb.key_count >= NumKeys - 1) k = (pick < 30) ? KindRemove :
                                                   (pick < 45) ? KindInsert : KindEval;
      else if (pick < 25) k = KindInsert;
      else if (pick < 40) k = KindRemove;
      else if (pick < 55) k = KindAlter;
      else k = KindEval;
      send_beat(k, pick_time(), $urandom,
                ($urandom_range(7) == 0 || ramp_sb.key_count == 0) ? 4'($urandom) :
                4'($urandom_range(ramp_sb.key_count - 1)));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extremes, ties, full table, bad indexes
    send_beat(KindEval, 16'd100, '0, '0);
    send_beat(KindRemove, '0, '0, 4'd0);
    send_beat(KindAlter, '0, '1, 4'd0);
    send_beat(KindInsert, 16'd0, 32'h00000000, '0);
    send_beat(KindInsert, 16'd25600, 32'hFFFFFFFF, '0);
    send_beat(KindEval, 16'd12800, '0, '0);
    send_beat(KindEval, 16'd0, '0, '0);
    send_beat(KindEval, 16'hFFFF, '0, '0);
    send_beat(KindInsert, 16'd12800, 32'h12345678, '0);
    send_beat(KindInsert, 16'd12800, 32'h87654321, '0);
    send_beat(KindEval, 16'd12800, '0, '0);
    send_beat(KindEval, 16'd6400, '0, '0);
    send_beat(KindEval, 16'd3, '0, '0);
    send_beat(KindAlter, 16'hFFFF, 32'hA5A5A5A5, 4'd1);
    send_beat(KindAlter, 16'd0, 32'h5A5A5A5A, 4'd3);
    send_beat(KindRemove, '0, '0, 4'd15);
    for (int i = 0; i < 13; i++) send_beat(KindInsert, 16'(i * 1000 + 7), $urandom, '0);
    send_beat(KindInsert, 16'd5, '1, '0);
    send_beat(KindEval, 16'd2000, '0, '0);
    drain();

    // Inverted range, then extremes
    write_range(CfgRangeStart, 16'd30000);
    write_range(CfgRangeEnd, 16'd1000);
    send_beat(KindEval, 16'd20000, '0, '0);
    send_beat(KindAlter, 16'd500, 32'h01020304, 4'd2);
    for (int i = 0; i < 16; i++) send_beat(KindRemove, '0, '0, '0);
    drain();

    idle_pct = 37;
    write_range(CfgRangeStart, 16'd0);
    write_range(CfgRangeEnd, 16'hFFFF);
    random_phase(270);
    drain();

    idle_pct = 76;
    write_range(CfgRangeStart, 16'd256);
    write_range(CfgRangeEnd, 16'd25600);
    random_phase(270);
    drain();

    idle_pct = 0;
    write_range(CfgRangeStart, 16'd1000);
    write_range(CfgRangeEnd, 16'd3000);
    random_phase(260);
    drain();

    if (ramp_sb.mismatches == 0 && ramp_sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
